### rtl/aphcm_pkg.sv
// Shared types and constants for the audio peak-hold and clip meter.
package aphcm_pkg;

  // Field widths
  localparam int unsigned CH_IN_W  = 3;
  localparam int unsigned LEVEL_W  = 17;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;

  // Default channel count
  localparam int unsigned CHANNELS_DEF = 8;

  // Q1.16 full scale and unity factor
  localparam logic [LEVEL_W-1:0] FULL_SCALE = 17'h10000;
  localparam logic [LEVEL_W-1:0] UNITY_Q16  = 17'h10000;

  // Register reset values
  localparam logic [COEF_W-1:0]  DECAY_RST = 16'd65385;
  localparam logic [TICK_W-1:0]  LATCH_RST = 16'd1000;
  localparam logic [LEVEL_W-1:0] FLOOR_RST = 17'd1;

  // Register indexes (word address)
  localparam logic [1:0] REG_DECAY = 2'd0;
  localparam logic [1:0] REG_LATCH = 2'd1;
  localparam logic [1:0] REG_FLOOR = 2'd2;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_POW   = 4'b0010,
    S_SCALE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture request and read channel state
    logic step;    // one square-and-multiply iteration
    logic scale;   // hold times decay factor
    logic finish;  // update channel state, load result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ticks_zero;  // no set tick bits left
    logic out_stall;   // result register full and not taken
  } stat_t;

endpackage

### rtl/aphcm_regs.sv
// Configuration register file behind the APB-style port.
module aphcm_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [aphcm_pkg::PADDR_W-1:0]       paddr,
  input  logic [aphcm_pkg::PDATA_W-1:0]       pwdata,
  output logic [aphcm_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready,
  output logic [aphcm_pkg::COEF_W-1:0]        decay,
  output logic [aphcm_pkg::TICK_W-1:0]        latch_ticks,
  output logic [aphcm_pkg::LEVEL_W-1:0]       floor_lvl
);

  logic [aphcm_pkg::COEF_W-1:0]  decay_r;
  logic [aphcm_pkg::TICK_W-1:0]  latch_r;
  logic [aphcm_pkg::LEVEL_W-1:0] floor_r;
  logic [1:0]                    idx;
  logic                          wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r <= aphcm_pkg::DECAY_RST;
      latch_r <= aphcm_pkg::LATCH_RST;
      floor_r <= aphcm_pkg::FLOOR_RST;
    end else if (wr_en) begin
      case (idx)
        aphcm_pkg::REG_DECAY: decay_r <= pwdata[aphcm_pkg::COEF_W-1:0];
        aphcm_pkg::REG_LATCH: latch_r <= pwdata[aphcm_pkg::TICK_W-1:0];
        aphcm_pkg::REG_FLOOR: floor_r <= pwdata[aphcm_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      aphcm_pkg::REG_DECAY: prdata = {16'd0, decay_r};
      aphcm_pkg::REG_LATCH: prdata = {16'd0, latch_r};
      aphcm_pkg::REG_FLOOR: prdata = {15'd0, floor_r};
      default:              prdata = '0;
    endcase
  end

  assign decay       = decay_r;
  assign latch_ticks = latch_r;
  assign floor_lvl   = floor_r;

endmodule

### rtl/aphcm_ctrl.sv
// Sequencing state machine for one meter update.
module aphcm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  aphcm_pkg::stat_t  stat,
  output aphcm_pkg::cmd_t   cmd
);

  aphcm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aphcm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      aphcm_pkg::S_IDLE: begin
        // no request is taken while reset is held
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = aphcm_pkg::S_POW;
        end
      end
      aphcm_pkg::S_POW: begin
        if (stat.ticks_zero) begin
          state_nxt = aphcm_pkg::S_SCALE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      aphcm_pkg::S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = aphcm_pkg::S_DONE;
      end
      aphcm_pkg::S_DONE: begin
        if (!stat.out_stall) begin
          cmd.finish = 1'b1;
          state_nxt  = aphcm_pkg::S_IDLE;
        end
      end
      default: state_nxt = aphcm_pkg::S_IDLE;
    endcase
  end

endmodule

### rtl/aphcm_dp.sv
// Datapath: channel state, decay power unit, clip countdown and result register.
module aphcm_dp #(
  parameter int unsigned CHANNELS = aphcm_pkg::CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  aphcm_pkg::cmd_t                     cmd,
  output aphcm_pkg::stat_t                    stat,
  input  logic [aphcm_pkg::COEF_W-1:0]        decay,
  input  logic [aphcm_pkg::TICK_W-1:0]        latch_ticks,
  input  logic [aphcm_pkg::LEVEL_W-1:0]       floor_lvl,
  input  logic [aphcm_pkg::CH_IN_W-1:0]       in_channel,
  input  logic [aphcm_pkg::LEVEL_W-1:0]       in_peak_level,
  input  logic [aphcm_pkg::LEVEL_W-1:0]       in_rms_level,
  input  logic                                in_playing,
  input  logic [aphcm_pkg::TICK_W-1:0]        in_elapsed_ticks,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [aphcm_pkg::CH_IN_W-1:0]       out_channel,
  output logic [aphcm_pkg::LEVEL_W-1:0]       out_shown_peak,
  output logic [aphcm_pkg::LEVEL_W-1:0]       out_shown_rms,
  output logic [aphcm_pkg::LEVEL_W-1:0]       out_hold_level,
  output logic                                out_clipped,
  output logic                                out_any_clipped
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [5:0]  CH_LIMIT = 6'(CHANNELS);
  localparam int unsigned LW = aphcm_pkg::LEVEL_W;
  localparam int unsigned TW = aphcm_pkg::TICK_W;
  localparam int unsigned CW = aphcm_pkg::COEF_W;

  // Per-channel state
  logic [LW-1:0] hold_mem [CHANNELS];
  logic [TW-1:0] cd_mem   [CHANNELS];

  // Working registers for the request in flight
  logic [aphcm_pkg::CH_IN_W-1:0] ch_r;
  logic [CH_W-1:0]               idx_r;
  logic                          in_rng_r;
  logic [LW-1:0]                 peak_r;
  logic [LW-1:0]                 rms_r;
  logic [TW-1:0]                 ticks_r;
  logic [TW-1:0]                 tsh_r;
  logic [LW-1:0]                 factor_r;
  logic [CW-1:0]                 base_r;
  logic [LW-1:0]                 hold_r;
  logic [TW-1:0]                 cd_r;

  // Result register
  logic                          ovalid_r;
  logic [aphcm_pkg::CH_IN_W-1:0] och_r;
  logic [LW-1:0]                 opeak_r;
  logic [LW-1:0]                 orms_r;
  logic [LW-1:0]                 ohold_r;
  logic                          oclip_r;
  logic                          oany_r;

  logic [CH_W-1:0]  in_idx;
  logic             in_rng;
  logic [LW-1:0]    mul_a;
  logic [LW-1:0]    mul_b;
  logic [2*LW-1:0]  mul_p;
  logic [2*CW-1:0]  sq_p;
  logic [LW-1:0]    hold_flr;
  logic [LW-1:0]    hold_new;
  logic [TW-1:0]    cd_new;
  logic             any_new;

  assign in_idx = CH_W'(in_channel);
  assign in_rng = ({3'd0, in_channel} < CH_LIMIT);

  // Shared multiplier: factor*base while iterating, hold*factor when scaling
  assign mul_a = cmd.scale ? hold_r : factor_r;
  assign mul_b = cmd.scale ? factor_r : {1'b0, base_r};
  assign mul_p = mul_a * mul_b;
  assign sq_p  = base_r * base_r;

  // Floor, peak raise and countdown update
  always_comb begin
    hold_flr = (hold_r < floor_lvl) ? '0 : hold_r;
    hold_new = (peak_r > hold_flr) ? peak_r : hold_flr;
    if (peak_r >= aphcm_pkg::FULL_SCALE) begin
      cd_new = latch_ticks;
    end else if (cd_r > ticks_r) begin
      cd_new = cd_r - ticks_r;
    end else begin
      cd_new = '0;
    end
  end

  // Clip OR over all channels with this channel's new countdown
  always_comb begin
    any_new = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (in_rng_r && (idx_r == CH_W'(c))) begin
        any_new = any_new | (cd_new != '0);
      end else begin
        any_new = any_new | (cd_mem[c] != '0);
      end
    end
  end

  // Request capture and decay power iteration
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r     <= in_channel;
      idx_r    <= in_idx;
      in_rng_r <= in_rng;
      peak_r   <= in_playing ? in_peak_level : '0;
      rms_r    <= in_playing ? in_rms_level : '0;
      ticks_r  <= in_elapsed_ticks;
      tsh_r    <= in_elapsed_ticks;
      factor_r <= aphcm_pkg::UNITY_Q16;
      base_r   <= decay;
      hold_r   <= in_rng ? hold_mem[in_idx] : '0;
      cd_r     <= in_rng ? cd_mem[in_idx] : '0;
    end else if (cmd.step) begin
      if (tsh_r[0]) begin
        factor_r <= mul_p[32:16];
      end
      base_r <= sq_p[31:16];
      tsh_r  <= tsh_r >> 1;
    end else if (cmd.scale) begin
      hold_r <= mul_p[32:16];
    end
  end

  // Channel state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        hold_mem[c] <= '0;
        cd_mem[c]   <= '0;
      end
    end else if (cmd.finish && in_rng_r) begin
      hold_mem[idx_r] <= hold_new;
      cd_mem[idx_r]   <= cd_new;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.finish) begin
      ovalid_r <= 1'b1;
    end else if (out_ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      och_r   <= ch_r;
      opeak_r <= peak_r;
      orms_r  <= rms_r;
      ohold_r <= in_rng_r ? hold_new : '0;
      oclip_r <= in_rng_r && (cd_new != '0);
      oany_r  <= any_new;
    end
  end

  assign stat.ticks_zero = (tsh_r == '0);
  assign stat.out_stall  = ovalid_r & ~out_ready;

  assign out_valid       = ovalid_r;
  assign out_channel     = och_r;
  assign out_shown_peak  = opeak_r;
  assign out_shown_rms   = orms_r;
  assign out_hold_level  = ohold_r;
  assign out_clipped     = oclip_r;
  assign out_any_clipped = oany_r;

endmodule

### rtl/audio_peak_hold_clip_meter.sv
// Top level of the audio peak-hold and clip meter.
// Each request updates one channel: the stored hold is decayed by
// decay_per_tick raised to elapsed_ticks (square-and-multiply, one tick bit per
// cycle, multiplies in a shared 17x17 multiplier), floored, raised to the gated
// peak, and the clip countdown is reloaded or run down. After acceptance the
// decay power loop steps over the bits up to the highest set bit of
// elapsed_ticks, the hold is scaled, and the done state waits until the result
// register is free or being taken; the decay power loop sets the time taken. A new
// request is taken once the previous one has moved into the result register,
// even while that result waits to be taken. Channels at or above CHANNELS
// change no state and report a hold of zero.
module audio_peak_hold_clip_meter #(
  parameter int unsigned CHANNELS = aphcm_pkg::CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [aphcm_pkg::CH_IN_W-1:0]       in_channel,
  input  logic [aphcm_pkg::LEVEL_W-1:0]       in_peak_level,
  input  logic [aphcm_pkg::LEVEL_W-1:0]       in_rms_level,
  input  logic                                in_playing,
  input  logic [aphcm_pkg::TICK_W-1:0]        in_elapsed_ticks,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [aphcm_pkg::CH_IN_W-1:0]       out_channel,
  output logic [aphcm_pkg::LEVEL_W-1:0]       out_shown_peak,
  output logic [aphcm_pkg::LEVEL_W-1:0]       out_shown_rms,
  output logic [aphcm_pkg::LEVEL_W-1:0]       out_hold_level,
  output logic                                out_clipped,
  output logic                                out_any_clipped,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [aphcm_pkg::PADDR_W-1:0]       paddr,
  input  logic [aphcm_pkg::PDATA_W-1:0]       pwdata,
  output logic [aphcm_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready
);

  aphcm_pkg::cmd_t                  cmd;
  aphcm_pkg::stat_t                 stat;
  logic [aphcm_pkg::COEF_W-1:0]     decay;
  logic [aphcm_pkg::TICK_W-1:0]     latch_ticks;
  logic [aphcm_pkg::LEVEL_W-1:0]    floor_lvl;

  aphcm_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .decay       (decay),
    .latch_ticks (latch_ticks),
    .floor_lvl   (floor_lvl)
  );

  aphcm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  aphcm_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .decay            (decay),
    .latch_ticks      (latch_ticks),
    .floor_lvl        (floor_lvl),
    .in_channel       (in_channel),
    .in_peak_level    (in_peak_level),
    .in_rms_level     (in_rms_level),
    .in_playing       (in_playing),
    .in_elapsed_ticks (in_elapsed_ticks),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_channel      (out_channel),
    .out_shown_peak   (out_shown_peak),
    .out_shown_rms    (out_shown_rms),
    .out_hold_level   (out_hold_level),
    .out_clipped      (out_clipped),
    .out_any_clipped  (out_any_clipped)
  );

  // One request in flight: no second acceptance right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  // A clipped channel must show in the all-channel flag
  a_any_covers: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |-> out_any_clipped)
    else $error("clipped set without any_clipped");

  // Hold of a valid channel never falls below the shown peak
  a_hold_ge_peak: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_channel < CHANNELS)) |-> (out_hold_level >= out_shown_peak))
    else $error("hold below shown peak");

endmodule

### tb/sv/audio_peak_hold_clip_meter_test.sv
// Self-checking testbench for the audio peak-hold and clip meter.
module audio_peak_hold_clip_meter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import aphcm_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned HOLD_AT      = 400;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned DRAIN_CYCLES = 24;

  // One level update as presented on the request channel
  typedef struct {
    logic [CH_IN_W-1:0] channel;
    logic [LEVEL_W-1:0] peak;
    logic [LEVEL_W-1:0] rms;
    logic               playing;
    logic [TICK_W-1:0]  ticks;
  } level_req_t;

  // One meter reading as returned on the result channel
  typedef struct {
    logic [CH_IN_W-1:0] channel;
    logic [LEVEL_W-1:0] peak;
    logic [LEVEL_W-1:0] rms;
    logic [LEVEL_W-1:0] hold;
    logic               clipped;
    logic               any_clipped;
  } meter_reading_t;

  // Tracks hold and clip state per channel and the readings still owed
  class meter_scoreboard;
    logic [COEF_W-1:0]  decay;
    logic [TICK_W-1:0]  latch;
    logic [LEVEL_W-1:0] floor_lvl;
    logic [LEVEL_W-1:0] hold_mem [CHANNELS_DEF];
    logic [TICK_W-1:0]  countdown [CHANNELS_DEF];
    meter_reading_t     expected_readings [$];
    int unsigned        failures;
    int unsigned        requests;
    int unsigned        readings;
    int unsigned        clips;

    function new();
      decay     = DECAY_RST;
      latch     = LATCH_RST;
      floor_lvl = FLOOR_RST;
      foreach (hold_mem[c]) begin
        hold_mem[c]  = '0;
        countdown[c] = '0;
      end
      failures = 0;
      requests = 0;
      readings = 0;
      clips    = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_DECAY: decay = value[COEF_W-1:0];
        REG_LATCH: latch = value[TICK_W-1:0];
        REG_FLOOR: floor_lvl = value[LEVEL_W-1:0];
        default: ;
      endcase
    endfunction

    // decay raised to ticks, square-and-multiply over the tick bits in Q1.16
    function logic [LEVEL_W-1:0] decay_factor(logic [TICK_W-1:0] ticks);
      logic [63:0] factor;
      logic [63:0] base;
      factor = 64'd65536;
      base   = 64'(decay);
      for (int b = 0; b < TICK_W; b++) begin
        if (ticks[b]) factor = (factor * base) >> 16;
        base = (base * base) >> 16;
      end
      return factor[LEVEL_W-1:0];
    endfunction

    function void note_request(level_req_t r);
      meter_reading_t     e;
      logic [63:0]        scaled;
      logic [LEVEL_W-1:0] gpeak;
      logic [LEVEL_W-1:0] h;
      logic [TICK_W-1:0]  cd;
      gpeak         = r.playing ? r.peak : '0;
      e.channel     = r.channel;
      e.peak        = gpeak;
      e.rms         = r.playing ? r.rms : '0;
      e.hold        = '0;
      e.clipped     = 1'b0;
      e.any_clipped = 1'b0;
      if (int'(r.channel) < int'(CHANNELS_DEF)) begin
        scaled = (64'(hold_mem[r.channel]) * 64'(decay_factor(r.ticks))) >> 16;
        h = scaled[LEVEL_W-1:0];
        if (h < floor_lvl) h = '0;
        if (gpeak > h) h = gpeak;
        hold_mem[r.channel] = h;
        // full-scale peak reloads the latch, otherwise it runs down
        cd = countdown[r.channel];
        if (gpeak >= FULL_SCALE) cd = latch;
        else cd = (cd > r.ticks) ? cd - r.ticks : '0;
        countdown[r.channel] = cd;
        e.hold    = h;
        e.clipped = (cd != '0);
      end
      foreach (countdown[c]) if (countdown[c] != '0) e.any_clipped = 1'b1;
      expected_readings.push_back(e);
      requests++;
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        failures++;
      end
    endfunction

    function void check_reading(meter_reading_t a);
      meter_reading_t e;
      if (expected_readings.size() == 0) begin
        $error("reading for channel %0d with no request pending", a.channel);
        failures++;
        return;
      end
      e = expected_readings.pop_front();
      readings++;
      if (a.clipped === 1'b1) clips++;
      compare_field("out_channel", 32'(e.channel), 32'(a.channel));
      compare_field("shown_peak", 32'(e.peak), 32'(a.peak));
      compare_field("shown_rms", 32'(e.rms), 32'(a.rms));
      compare_field("hold_level", 32'(e.hold), 32'(a.hold));
      compare_field("clipped", 32'(e.clipped), 32'(a.clipped));
      compare_field("any_clipped", 32'(e.any_clipped), 32'(a.any_clipped));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [CH_IN_W-1:0]  in_channel;
  logic [LEVEL_W-1:0]  in_peak_level;
  logic [LEVEL_W-1:0]  in_rms_level;
  logic                in_playing;
  logic [TICK_W-1:0]   in_elapsed_ticks;
  logic                out_valid;
  logic                out_ready;
  logic [CH_IN_W-1:0]  out_channel;
  logic [LEVEL_W-1:0]  out_shown_peak;
  logic [LEVEL_W-1:0]  out_shown_rms;
  logic [LEVEL_W-1:0]  out_hold_level;
  logic                out_clipped;
  logic                out_any_clipped;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  meter_scoreboard board;
  int unsigned     settings_applied;
  int unsigned     held_cycles;

  audio_peak_hold_clip_meter #(
    .CHANNELS(CHANNELS_DEF)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_channel       (in_channel),
    .in_peak_level    (in_peak_level),
    .in_rms_level     (in_rms_level),
    .in_playing       (in_playing),
    .in_elapsed_ticks (in_elapsed_ticks),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_channel      (out_channel),
    .out_shown_peak   (out_shown_peak),
    .out_shown_rms    (out_shown_rms),
    .out_hold_level   (out_hold_level),
    .out_clipped      (out_clipped),
    .out_any_clipped  (out_any_clipped),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic level_req_t mk_req(int unsigned ch, int unsigned peak,
                                        int unsigned rms, bit play,
                                        int unsigned ticks);
    level_req_t r;
    r.channel = ch[CH_IN_W-1:0];
    r.peak    = peak[LEVEL_W-1:0];
    r.rms     = rms[LEVEL_W-1:0];
    r.playing = play;
    r.ticks   = ticks[TICK_W-1:0];
    return r;
  endfunction

  // Mostly realistic updates, with some clips, stopped transport and raw noise
  function automatic level_req_t random_req();
    level_req_t  r;
    int unsigned p;
    int unsigned q;
    p = $urandom_range(0, 99);
    q = $urandom_range(0, 99);
    r.channel = CH_IN_W'($urandom_range(0, CHANNELS_DEF - 1));
    r.playing = ($urandom_range(0, 9) != 0);
    if (p < 70) r.peak = LEVEL_W'($urandom_range(0, 65535));
    else if (p < 80) r.peak = LEVEL_W'($urandom_range(65536, 131071));
    else if (p < 88) r.peak = '0;
    else r.peak = LEVEL_W'($urandom);
    if ($urandom_range(0, 3) != 0) r.rms = LEVEL_W'($urandom_range(0, r.peak));
    else r.rms = LEVEL_W'($urandom);
    if (q < 55) r.ticks = TICK_W'($urandom_range(0, 40));
    else if (q < 75) r.ticks = TICK_W'($urandom_range(0, 1000));
    else if (q < 85) r.ticks = '0;
    else r.ticks = TICK_W'($urandom);
    return r;
  endfunction

  // Gap after a request: mostly none or short, now and then long
  function automatic int unsigned pick_gap(bit steady);
    int unsigned p;
    if (steady) return 0;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  task automatic send_request(level_req_t r, int unsigned gap);
    in_valid         <= 1'b1;
    in_channel       <= r.channel;
    in_peak_level    <= r.peak;
    in_rms_level     <= r.rms;
    in_playing       <= r.playing;
    in_elapsed_ticks <= r.ticks;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(r);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write one register, then read it back in the following transfer
  task automatic cfg_write_check(logic [1:0] idx, logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] readback;
    case (idx)
      REG_FLOOR: readback = value & 32'h1FFFF;
      default:   readback = value & 32'h0FFFF;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.set_register(idx, value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== readback) begin
      $error("register %0d: expected %0d, got %0d", idx, readback, prdata);
      board.failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every reading owed, then for the pipeline to empty
  task automatic settle();
    while (board.expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(int unsigned decay, int unsigned latch,
                               int unsigned floor_lvl);
    cfg_write_check(REG_DECAY, decay);
    cfg_write_check(REG_LATCH, latch);
    cfg_write_check(REG_FLOOR, floor_lvl);
    settings_applied++;
  endtask

  task automatic run_random(int unsigned count);
    bit          steady;
    int unsigned gap;
    steady = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      gap = pick_gap(steady);
      if (i == count - 1 && gap == 0) gap = 1;
      send_request(random_req(), gap);
    end
  endtask

  // Field extremes, clip load and run-down, stopped transport, floor, tick bits
  task automatic run_directed();
    level_req_t list [$];
    int unsigned gap;
    list.push_back(mk_req(0, 0, 0, 1, 0));
    list.push_back(mk_req(0, 65536, 40000, 1, 0));
    list.push_back(mk_req(0, 65535, 65535, 1, 1));
    list.push_back(mk_req(0, 0, 0, 1, 65535));
    list.push_back(mk_req(1, 131071, 131071, 1, 65535));
    list.push_back(mk_req(1, 131071, 131071, 0, 10));
    list.push_back(mk_req(1, 0, 0, 1, 0));
    list.push_back(mk_req(2, 65535, 1, 1, 0));
    list.push_back(mk_req(2, 0, 0, 1, 1));
    list.push_back(mk_req(2, 0, 0, 1, 16'h8000));
    list.push_back(mk_req(2, 70000, 0, 1, 16'h5555));
    list.push_back(mk_req(2, 0, 0, 1, 16'hAAAA));
    list.push_back(mk_req(3, 65536, 100, 0, 0));
    list.push_back(mk_req(3, 65536, 100, 1, 0));
    list.push_back(mk_req(4, 65536, 0, 1, 0));
    list.push_back(mk_req(4, 100, 0, 1, 999));
    list.push_back(mk_req(4, 100, 0, 1, 1));
    list.push_back(mk_req(5, 65536, 0, 1, 0));
    list.push_back(mk_req(5, 0, 0, 1, 1000));
    list.push_back(mk_req(7, 1, 0, 1, 0));
    list.push_back(mk_req(7, 0, 0, 1, 1));
    list.push_back(mk_req(6, 65535, 131071, 1, 0));
    foreach (list[i]) begin
      gap = pick_gap(1'b0);
      if (i == list.size() - 1 && gap == 0) gap = 1;
      send_request(list[i], gap);
    end
  endtask

  // Request side and overall sequencing
  initial begin
    board            = new();
    settings_applied = 0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_channel       = '0;
    in_peak_level    = '0;
    in_rms_level     = '0;
    in_playing       = 1'b0;
    in_elapsed_ticks = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults
    run_directed();
    run_random(300);
    settle();

    // slowest decay, longest latch, no floor
    apply_setting(65535, 65535, 0);
    run_random(250);
    settle();

    // instant decay, no latch, floor at the highest level
    apply_setting(0, 0, 131071);
    run_random(200);
    settle();

    apply_setting(60000, 50, 100);
    run_random(300);
    settle();

    apply_setting(32768, 1, 65536);
    run_random(200);
    settle();

    apply_setting($urandom_range(60000, 65535), $urandom_range(0, 2000),
                  $urandom_range(0, 300));
    run_random(350);
    settle();

    $display("Covered %0d requests and %0d readings over %0d register settings",
             board.requests, board.readings, settings_applied);
    $display("%0d readings showed a clip; result side held off for %0d cycles",
             board.clips, held_cycles);
    if (board.failures == 0 && board.expected_readings.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side: random stalls, steady stretches, one long hold-off
  initial begin
    meter_reading_t a;
    int unsigned    stall_left;
    int unsigned    hold_left;
    int unsigned    cycle;
    bit             steady;
    out_ready   = 1'b0;
    held_cycles = 0;
    stall_left  = 0;
    hold_left   = 0;
    cycle       = 0;
    steady      = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      cycle++;
      if (out_valid && out_ready) begin
        a.channel     = out_channel;
        a.peak        = out_shown_peak;
        a.rms         = out_shown_rms;
        a.hold        = out_hold_level;
        a.clipped     = out_clipped;
        a.any_clipped = out_any_clipped;
        board.check_reading(a);
        if (board.readings == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (cycle % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
        held_cycles++;
      end else if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!steady) begin
          case ($urandom_range(0, 19))
            0, 1, 2: stall_left = $urandom_range(1, 3);
            3:       stall_left = $urandom_range(10, 60);
            default: stall_left = 0;
          endcase
        end
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no transfer anywhere
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/aphcm_pkg.sv
rtl/aphcm_regs.sv
rtl/aphcm_ctrl.sv
rtl/aphcm_dp.sv
rtl/audio_peak_hold_clip_meter.sv
tb/sv/audio_peak_hold_clip_meter_test.sv
